### design/mic_pkg.sv
// ----------------------------------------------------------------------------
// mic_pkg
// Shared widths, codes and saturation helper for the magnetometer iron
// calibration block.
// ----------------------------------------------------------------------------
`default_nettype none

package mic_pkg;

    // Field values carry this many fractional bits of a microtesla
    localparam int FIELD_FRACTION_BITS = 6;

    localparam int FIELD_W   = 20;
    localparam int SCALE_W   = 16;
    localparam int SCALE_FRAC = 14;
    localparam int ADJ_W     = 8;
    localparam int SENS_W    = ADJ_W + 1;
    localparam int RAW_W     = 16;
    localparam int STATUS_W  = 8;
    localparam int N_AXES    = 3;
    localparam int AXIS_W    = $clog2(N_AXES);
    localparam int CMD_W     = 2;
    localparam int OUTCOME_W = 3;
    localparam int CFG_INDEX_W = $clog2(N_AXES);

    localparam int IN_TDATA_W  = ((N_AXES * RAW_W + STATUS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((N_AXES * FIELD_W + 7) / 8) * 8;
    localparam int STATUS_LSB  = N_AXES * RAW_W;
    localparam int OVF_BIT     = 3;
    localparam int OVF_POS     = STATUS_LSB + OVF_BIT;

    // Command codes (the spare code behaves as a measurement)
    localparam logic [CMD_W-1:0] CMD_MEASURE     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINISH      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_MEASURE_ALT = 2'd3;

    // Outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_MEASURED   = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_OVERFLOW   = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_SAMPLED    = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_CALIBRATED = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_CAL_FAILED = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ADJUST_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ADJUST_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ADJUST_Z = 2'd2;

    localparam logic [ADJ_W-1:0] ADJ_RESET = 8'd128;
    localparam int ADJ_OFFSET = 128;
    localparam int ADJ_MAX    = (1 << ADJ_W) - 1;

    // Axis value: round(|raw| * sens * 3 * 2^F / 5120), done as
    // (6 * |raw| * sens * 2^F + 5120) / 10240 on magnitudes
    localparam longint AX_ROUND   = 5120;
    localparam longint AX_DIVISOR = 2 * AX_ROUND;
    localparam int     AX_PROD_W  = RAW_W + SENS_W;
    localparam longint AX_PROD_MAX = (longint'(1) << (RAW_W - 1)) * (ADJ_MAX + ADJ_OFFSET);
    localparam longint AXN_MAX =
        AX_PROD_MAX * 6 * (longint'(1) << FIELD_FRACTION_BITS) + AX_ROUND;
    localparam int AXN_W = $clog2(AXN_MAX + 1);
    localparam int AX_QW = $clog2(AXN_MAX / AX_DIVISOR + 1);

    // Shared shift-add multiplier
    localparam int MUL_A_W = FIELD_W + 1;
    localparam int MUL_B_W = SCALE_W;
    localparam int ACC_W   = MUL_A_W + MUL_B_W;
    localparam int MEAS_QW = ACC_W - SCALE_FRAC;

    // Finish: scale = (2 * total * 2^14 + 3r) / 6r
    localparam int TOTAL_W   = FIELD_W + 2;
    localparam int FIN_NUM_W = TOTAL_W + SCALE_FRAC + 1;
    localparam int FIN_HI_W  = FIN_NUM_W - SCALE_W;
    localparam int DEN_W     = FIELD_W + 3;

    // Shared restoring divider
    localparam int AX_DEN_W = $clog2(AX_DIVISOR + 1);
    localparam int REM_W    = (DEN_W > AX_DEN_W) ? DEN_W : AX_DEN_W;
    localparam int QSW      = (AX_QW > SCALE_W) ? AX_QW : SCALE_W;
    localparam int CNT_W    = $clog2(QSW + 1);

    localparam int SATIN_W  = (AX_QW > MEAS_QW) ? AX_QW : MEAS_QW;

    localparam logic [SCALE_W-1:0] SCALE_ONE   = 16'd16384;
    localparam logic [SCALE_W-1:0] SCALE_MAX   = 16'hFFFF;
    localparam logic [SCALE_W-1:0] SCALE_FLOOR = SCALE_ONE / 3;

    localparam longint FIELD_MAX_VAL = (longint'(1) << (FIELD_W - 1)) - 1;

    typedef logic signed [FIELD_W-1:0] t_field;

    localparam t_field FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam t_field FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

    // Apply a sign to a magnitude and clamp to the field range
    function automatic t_field sat_field(input logic neg, input logic [SATIN_W-1:0] mag);
        t_field res;
        if (!neg) begin
            res = (mag > SATIN_W'(FIELD_MAX_VAL)) ? FIELD_MAX : t_field'(mag[FIELD_W-1:0]);
        end else begin
            res = (mag > SATIN_W'(FIELD_MAX_VAL + 1)) ? FIELD_MIN
                                                      : t_field'(-mag[FIELD_W-1:0]);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### design/magnetometer_iron_calibration_top.sv
// Work runs on the shared bit-serial multiplier (9 or 16 steps) and the shared
// restoring divider (19 or 16 steps), axes in turn: a sample uses each once per axis,
// a measurement the multiplier twice and the divider once per axis, a finish the
// divider once per axis; an overflow reject or a degenerate finish uses neither.
// One item at a time: the next transaction can be taken from the cycle tvalid rises.
// Synchronous active-low reset restores adjust bytes, extremes, bias and scale.
// ----------------------------------------------------------------------------
// magnetometer_iron_calibration_top
// Scales raw magnetometer samples, tracks per-axis extremes and derives
// hard-iron bias and soft-iron scale, then corrects measurements.
// ----------------------------------------------------------------------------
`default_nettype none

module magnetometer_iron_calibration_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [mic_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [mic_pkg::ADJ_W-1:0]          i_cfg_data,
    // input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // x_low_byte, x_high_byte, y_low_byte, y_high_byte, z_low_byte, z_high_byte,
    // sensor_status
    input  wire logic [mic_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // command
    input  wire logic [mic_pkg::CMD_W-1:0]          s_axis_tuser,
    // result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // field_x, field_y, field_z, zero padding
    output logic [mic_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // outcome
    output logic [mic_pkg::OUTCOME_W-1:0]           m_axis_tuser
);

    import mic_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE        = 11'b000_0000_0001,
        ST_AX_LOAD     = 11'b000_0000_0010,
        ST_MUL         = 11'b000_0000_0100,
        ST_AX_DIV_LOAD = 11'b000_0000_1000,
        ST_DIV         = 11'b000_0001_0000,
        ST_AX_DONE     = 11'b000_0010_0000,
        ST_MEAS_DONE   = 11'b000_0100_0000,
        ST_FIN_CHECK   = 11'b000_1000_0000,
        ST_FIN_LOAD    = 11'b001_0000_0000,
        ST_FIN_STORE   = 11'b010_0000_0000,
        ST_OUT         = 11'b100_0000_0000
    } t_state;

    localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(N_AXES - 1);

    // control and architectural state
    t_state                 r_state, n_state;
    logic                   r_out_valid, n_out_valid;
    logic [ADJ_W-1:0]       r_adj   [N_AXES];
    logic [ADJ_W-1:0]       n_adj   [N_AXES];
    t_field                 r_min   [N_AXES];
    t_field                 n_min   [N_AXES];
    t_field                 r_max   [N_AXES];
    t_field                 n_max   [N_AXES];
    t_field                 r_bias  [N_AXES];
    t_field                 n_bias  [N_AXES];
    logic [SCALE_W-1:0]     r_scale [N_AXES];
    logic [SCALE_W-1:0]     n_scale [N_AXES];

    // working registers
    logic [AXIS_W-1:0]      r_axis, n_axis;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [CMD_W-1:0]       r_cmd, n_cmd;
    logic [IN_TDATA_W-1:0]  r_data, n_data;
    logic                   r_mul_meas, n_mul_meas;
    logic                   r_neg, n_neg;
    logic                   r_sat, n_sat;
    logic [MUL_A_W-1:0]     r_mc, n_mc;
    logic [MUL_B_W-1:0]     r_ml, n_ml;
    logic [ACC_W-1:0]       r_acc, n_acc;
    logic [REM_W-1:0]       r_rem, n_rem;
    logic [REM_W-1:0]       r_den, n_den;
    logic [QSW-1:0]         r_q, n_q;
    logic [TOTAL_W-1:0]     r_total, n_total;
    t_field                 r_res   [N_AXES];
    t_field                 n_res   [N_AXES];
    logic [OUTCOME_W-1:0]   r_outcome, n_outcome;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic [OUTCOME_W-1:0]   r_out_user, n_out_user;

    // datapath
    logic [RAW_W-1:0]       raw, raw_mag;
    logic                   raw_neg;
    logic [SENS_W-1:0]      sens;
    logic [AXN_W-1:0]       ax_num;
    t_field                 ax_val;
    logic [FIELD_W:0]       dev;
    logic                   dev_neg;
    logic [MUL_A_W-1:0]     dev_mag;
    logic [ACC_W-1:0]       meas_sum;
    t_field                 meas_val;
    logic [ACC_W-1:0]       mul_acc;
    logic [REM_W:0]         div_shift;
    logic [REM_W+1:0]       div_diff;
    logic                   div_bit;
    logic [REM_W-1:0]       div_rem;
    logic [FIELD_W:0]       rng [N_AXES];
    logic                   rng_ok;
    logic [TOTAL_W-1:0]     rng_total;
    logic [FIELD_W-1:0]     rng_cur;
    logic [FIELD_W+1:0]     rng3;
    logic [DEN_W-1:0]       den6;
    logic [FIN_NUM_W-1:0]   fin_num;
    logic [FIN_HI_W-1:0]    fin_hi;
    logic                   fin_sat;
    logic [FIELD_W:0]       bsum;
    logic                   bneg;
    logic [FIELD_W:0]       bmag, bmag1;
    t_field                 bias_val;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // axis scaling
    assign raw     = r_data[RAW_W*r_axis +: RAW_W];
    assign raw_neg = raw[RAW_W-1];
    assign raw_mag = raw_neg ? -raw : raw;
    assign sens    = {1'b0, r_adj[r_axis]} + SENS_W'(ADJ_OFFSET);
    assign ax_num  = (AXN_W'(r_acc[AX_PROD_W-1:0]) << (FIELD_FRACTION_BITS + 2))
                   + (AXN_W'(r_acc[AX_PROD_W-1:0]) << (FIELD_FRACTION_BITS + 1))
                   + AXN_W'(AX_ROUND);
    assign ax_val  = sat_field(r_neg, SATIN_W'(r_q[AX_QW-1:0]));

    // measurement correction
    assign dev      = {ax_val[FIELD_W-1], ax_val} - {r_bias[r_axis][FIELD_W-1], r_bias[r_axis]};
    assign dev_neg  = dev[FIELD_W];
    assign dev_mag  = dev_neg ? -dev : dev;
    assign meas_sum = r_acc + ACC_W'(1 << (SCALE_FRAC - 1));
    assign meas_val = sat_field(r_neg, SATIN_W'(meas_sum[ACC_W-1:SCALE_FRAC]));

    // one multiplier bit per cycle, most significant first
    assign mul_acc = (r_acc << 1) + (r_ml[MUL_B_W-1] ? ACC_W'(r_mc) : '0);

    // one quotient bit per cycle
    assign div_shift = {r_rem, r_q[QSW-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, r_den};
    assign div_bit   = ~div_diff[REM_W+1];
    assign div_rem   = div_bit ? div_diff[REM_W-1:0] : div_shift[REM_W-1:0];

    // calibration finish
    always_comb begin
        rng_ok = 1'b1;
        for (int k = 0; k < N_AXES; k++) begin
            rng[k] = {r_max[k][FIELD_W-1], r_max[k]} - {r_min[k][FIELD_W-1], r_min[k]};
            if (rng[k][FIELD_W] || (rng[k] == '0)) begin
                rng_ok = 1'b0;
            end
        end
    end

    assign rng_total = TOTAL_W'(rng[0][FIELD_W-1:0]) + TOTAL_W'(rng[1][FIELD_W-1:0])
                     + TOTAL_W'(rng[2][FIELD_W-1:0]);
    assign rng_cur   = rng[r_axis][FIELD_W-1:0];
    assign rng3      = ((FIELD_W+2)'(rng_cur) << 1) + (FIELD_W+2)'(rng_cur);
    assign den6      = DEN_W'(rng3) << 1;
    assign fin_num   = (FIN_NUM_W'(r_total) << (SCALE_FRAC + 1)) + FIN_NUM_W'(rng3);
    assign fin_hi    = fin_num[FIN_NUM_W-1:SCALE_W];
    // quotient beyond the scale width: clamp
    assign fin_sat   = (DEN_W'(fin_hi) >= den6);

    assign bsum     = {r_max[r_axis][FIELD_W-1], r_max[r_axis]}
                    + {r_min[r_axis][FIELD_W-1], r_min[r_axis]};
    assign bneg     = bsum[FIELD_W];
    assign bmag     = bneg ? -bsum : bsum;
    assign bmag1    = bmag + 1'b1;
    assign bias_val = sat_field(bneg, SATIN_W'(bmag1[FIELD_W:1]));

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_adj       = r_adj;
        n_min       = r_min;
        n_max       = r_max;
        n_bias      = r_bias;
        n_scale     = r_scale;
        n_axis      = r_axis;
        n_cnt       = r_cnt;
        n_cmd       = r_cmd;
        n_data      = r_data;
        n_mul_meas  = r_mul_meas;
        n_neg       = r_neg;
        n_sat       = r_sat;
        n_mc        = r_mc;
        n_ml        = r_ml;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_den       = r_den;
        n_q         = r_q;
        n_total     = r_total;
        n_res       = r_res;
        n_outcome   = r_outcome;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ADJUST_X: n_adj[0] = i_cfg_data;
                REG_ADJUST_Y: n_adj[1] = i_cfg_data;
                REG_ADJUST_Z: n_adj[2] = i_cfg_data;
                default: ;
            endcase
        end

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd  = s_axis_tuser;
                    n_data = s_axis_tdata;
                    n_axis = '0;
                    for (int k = 0; k < N_AXES; k++) begin
                        n_res[k] = '0;
                    end
                    if (s_axis_tuser == CMD_FINISH) begin
                        n_state = ST_FIN_CHECK;
                    end else if (s_axis_tdata[OVF_POS]) begin
                        n_outcome = OUT_OVERFLOW;
                        n_state   = ST_OUT;
                    end else begin
                        n_state = ST_AX_LOAD;
                    end
                end
            end
            ST_AX_LOAD: begin
                n_mc       = MUL_A_W'(raw_mag);
                n_ml       = MUL_B_W'(sens) << (MUL_B_W - SENS_W);
                n_acc      = '0;
                n_cnt      = CNT_W'(SENS_W);
                n_neg      = raw_neg;
                n_mul_meas = 1'b0;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                n_acc = mul_acc;
                n_ml  = r_ml << 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = r_mul_meas ? ST_MEAS_DONE : ST_AX_DIV_LOAD;
                end
            end
            ST_AX_DIV_LOAD: begin
                n_rem   = REM_W'(ax_num >> AX_QW);
                n_den   = REM_W'(AX_DIVISOR);
                n_q     = QSW'(ax_num[AX_QW-1:0]) << (QSW - AX_QW);
                n_cnt   = CNT_W'(AX_QW);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem = div_rem;
                n_q   = {r_q[QSW-2:0], div_bit};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = (r_cmd == CMD_FINISH) ? ST_FIN_STORE : ST_AX_DONE;
                end
            end
            ST_AX_DONE: begin
                if (r_cmd == CMD_SAMPLE) begin
                    if (ax_val < r_min[r_axis]) begin
                        n_min[r_axis] = ax_val;
                    end
                    if (ax_val > r_max[r_axis]) begin
                        n_max[r_axis] = ax_val;
                    end
                    n_res[r_axis] = ax_val;
                    if (r_axis == AXIS_LAST) begin
                        n_outcome = OUT_SAMPLED;
                        n_state   = ST_OUT;
                    end else begin
                        n_axis  = r_axis + 1'b1;
                        n_state = ST_AX_LOAD;
                    end
                end else begin
                    // remove bias, then run the scale through the multiplier
                    n_mc       = dev_mag;
                    n_ml       = r_scale[r_axis];
                    n_acc      = '0;
                    n_cnt      = CNT_W'(MUL_B_W);
                    n_neg      = dev_neg;
                    n_mul_meas = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MEAS_DONE: begin
                n_res[r_axis] = meas_val;
                if (r_axis == AXIS_LAST) begin
                    n_outcome = OUT_MEASURED;
                    n_state   = ST_OUT;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = ST_AX_LOAD;
                end
            end
            ST_FIN_CHECK: begin
                if (rng_ok) begin
                    n_total = rng_total;
                    n_axis  = '0;
                    n_state = ST_FIN_LOAD;
                end else begin
                    for (int k = 0; k < N_AXES; k++) begin
                        n_min[k] = FIELD_MAX;
                        n_max[k] = FIELD_MIN;
                    end
                    n_outcome = OUT_CAL_FAILED;
                    n_state   = ST_OUT;
                end
            end
            ST_FIN_LOAD: begin
                n_rem   = REM_W'(fin_hi);
                n_den   = REM_W'(den6);
                n_q     = QSW'(fin_num[SCALE_W-1:0]) << (QSW - SCALE_W);
                n_sat   = fin_sat;
                n_cnt   = CNT_W'(SCALE_W);
                n_state = ST_DIV;
            end
            ST_FIN_STORE: begin
                n_scale[r_axis] = r_sat ? SCALE_MAX : r_q[SCALE_W-1:0];
                n_bias[r_axis]  = bias_val;
                if (r_axis == AXIS_LAST) begin
                    for (int k = 0; k < N_AXES; k++) begin
                        n_min[k] = FIELD_MAX;
                        n_max[k] = FIELD_MIN;
                    end
                    n_outcome = OUT_CALIBRATED;
                    n_state   = ST_OUT;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = ST_FIN_LOAD;
                end
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_TDATA_W'({r_res[2], r_res[1], r_res[0]});
                    n_out_user  = r_outcome;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < N_AXES; k++) begin
                r_adj[k]   <= ADJ_RESET;
                r_min[k]   <= FIELD_MAX;
                r_max[k]   <= FIELD_MIN;
                r_bias[k]  <= '0;
                r_scale[k] <= SCALE_ONE;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_adj       <= n_adj;
            r_min       <= n_min;
            r_max       <= n_max;
            r_bias      <= n_bias;
            r_scale     <= n_scale;
        end
    end

    always_ff @(posedge i_clk) begin
        r_axis     <= n_axis;
        r_cnt      <= n_cnt;
        r_cmd      <= n_cmd;
        r_data     <= n_data;
        r_mul_meas <= n_mul_meas;
        r_neg      <= n_neg;
        r_sat      <= n_sat;
        r_mc       <= n_mc;
        r_ml       <= n_ml;
        r_acc      <= n_acc;
        r_rem      <= n_rem;
        r_den      <= n_den;
        r_q        <= n_q;
        r_total    <= n_total;
        r_res      <= n_res;
        r_outcome  <= n_outcome;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    // an overflowed measurement or sample goes straight to the output stage
    a_ovf_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser != CMD_FINISH)
         && s_axis_tdata[OVF_POS]) |=> (r_state == ST_OUT))
        else $error("overflowed transaction did not bypass the datapath");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_MUL) || (r_state == ST_DIV)) |-> (r_cnt != '0))
        else $error("serial step counter ran out while busy");

    a_meas_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MEAS_DONE) |-> ((r_cmd == CMD_MEASURE) || (r_cmd == CMD_MEASURE_ALT)))
        else $error("correction path taken for a non-measure command");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("result raised outside the output stage");

    // the range ratio can never fall below one third
    a_scale_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scale[0] >= SCALE_FLOOR) && (r_scale[1] >= SCALE_FLOOR)
        && (r_scale[2] >= SCALE_FLOOR))
        else $error("soft-iron scale below its lower bound");

endmodule

`default_nettype wire

### tb/sv/magnetometer_iron_calibration_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_iron_calibration_top_tb
// Drives raw magnetometer samples, calibration runs and finish commands into
// the iron calibration block. Sensitivity adjust bytes are rewritten between
// phases. Results are checked against a bit-exact predictor of the scaling, min-max
// calibration and correction arithmetic, or against the given outcome for typed rows.
// Both stream sides idle and stall in random bursts, except in the last phase.
// ----------------------------------------------------------------------------

module magnetometer_iron_calibration_top_tb;
    import mic_pkg::*;

    localparam int     N_RANDOM_ITEMS = 850;
    localparam int     N_PHASES       = 8;
    // 0.15 uT per LSB together with the /256 of the sensitivity gives 3/5120
    localparam longint LSB_DIVISOR    = 5120;
    localparam longint FIELD_LO       = -FIELD_MAX_VAL - 1;
    localparam logic [STATUS_W-1:0] OVF_MASK = STATUS_W'(1) << OVF_BIT;

    typedef struct packed {
        logic [CMD_W-1:0]             cmd;
        logic [N_AXES-1:0][RAW_W-1:0] raw;     // [0] is x
        logic [STATUS_W-1:0]          status;
    } t_mag_item;

    typedef struct packed {
        logic [OUTCOME_W-1:0]           outcome;
        logic [N_AXES-1:0][FIELD_W-1:0] fld;   // [0] is x
    } t_field_result;

    // Typed rows all carry zero fields; only the outcome is given
    typedef struct {
        t_mag_item            item;
        bit                   typed;
        logic [OUTCOME_W-1:0] outcome;
    } t_stim_row;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [ADJ_W-1:0]       i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [CMD_W-1:0]       s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUTCOME_W-1:0]   m_axis_tuser;

    logic [ADJ_W-1:0] adj_shadow   [N_AXES];
    longint           ext_min      [N_AXES];
    longint           ext_max      [N_AXES];
    longint           bias_shadow  [N_AXES];
    longint           scale_shadow [N_AXES];

    t_field_result expected_fields [$];
    t_stim_row     directed_rows   [$];
    int            n_errors = 0;
    bit            idle_on  = 1'b1;

    magnetometer_iron_calibration_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("magnetometer_iron_calibration_top verification failed");
        $finish;
    end

    function automatic longint clamp_field(input longint v);
        if (v > FIELD_MAX_VAL) return FIELD_MAX_VAL;
        if (v < FIELD_LO) return FIELD_LO;
        return v;
    endfunction

    // Round to nearest, halves away from zero; den is positive
    function automatic longint div_nearest(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (mag * 2 + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint scaled_axis(input logic [RAW_W-1:0] raw,
                                           input logic [ADJ_W-1:0] adj);
        longint num;
        num = longint'($signed(raw)) * (longint'(adj) + ADJ_OFFSET) * 3
              * (longint'(1) << FIELD_FRACTION_BITS);
        return clamp_field(div_nearest(num, LSB_DIVISOR));
    endfunction

    function automatic void clear_extremes();
        int a;
        for (a = 0; a < N_AXES; a++) begin
            ext_min[a] = FIELD_MAX_VAL;
            ext_max[a] = FIELD_LO;
        end
    endfunction

    function automatic t_field_result predict_fields(input t_mag_item it);
        t_field_result res;
        longint        span [N_AXES];
        longint        total;
        longint        q;
        longint        v;
        bit            ok;
        int            a;
        res = '0;
        if (it.cmd == CMD_FINISH) begin
            ok    = 1'b1;
            total = 0;
            for (a = 0; a < N_AXES; a++) begin
                span[a] = ext_max[a] - ext_min[a];
                if (span[a] <= 0) ok = 1'b0;
                total += span[a];
            end
            if (ok) begin
                for (a = 0; a < N_AXES; a++) begin
                    q = div_nearest(total * longint'(SCALE_ONE), 3 * span[a]);
                    bias_shadow[a]  = clamp_field(div_nearest(ext_max[a] + ext_min[a], 2));
                    scale_shadow[a] = (q > longint'(SCALE_MAX)) ? longint'(SCALE_MAX) : q;
                end
                res.outcome = OUT_CALIBRATED;
            end else begin
                res.outcome = OUT_CAL_FAILED;
            end
            clear_extremes();
        end else if ((it.status & OVF_MASK) != '0) begin
            res.outcome = OUT_OVERFLOW;
        end else if (it.cmd == CMD_SAMPLE) begin
            for (a = 0; a < N_AXES; a++) begin
                v = scaled_axis(it.raw[a], adj_shadow[a]);
                if (v < ext_min[a]) ext_min[a] = v;
                if (v > ext_max[a]) ext_max[a] = v;
                res.fld[a] = FIELD_W'(v);
            end
            res.outcome = OUT_SAMPLED;
        end else begin
            // measure, spare code included
            for (a = 0; a < N_AXES; a++) begin
                v = scaled_axis(it.raw[a], adj_shadow[a]) - bias_shadow[a];
                res.fld[a] = FIELD_W'(clamp_field(
                    div_nearest(v * scale_shadow[a], longint'(SCALE_ONE))));
            end
            res.outcome = OUT_MEASURED;
        end
        return res;
    endfunction

    function automatic t_mag_item mk_item(input logic [CMD_W-1:0] cmd,
                                          input logic [RAW_W-1:0] x, y, z,
                                          input logic [STATUS_W-1:0] status);
        t_mag_item it;
        it.cmd    = cmd;
        it.raw    = {z, y, x};
        it.status = status;
        return it;
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return RAW_W'($urandom_range(0, 400) - 200);
            default: return RAW_W'($urandom);
        endcase
    endfunction

    // Random status, overflow set about one time in ten
    function automatic logic [STATUS_W-1:0] quiet_status();
        logic [STATUS_W-1:0] st;
        st = STATUS_W'($urandom) & ~OVF_MASK;
        if ($urandom_range(0, 9) == 0) st = st | OVF_MASK;
        return st;
    endfunction

    task automatic add_row(input logic [CMD_W-1:0] cmd,
                           input logic [RAW_W-1:0] x, y, z,
                           input logic [STATUS_W-1:0] status,
                           input bit typed,
                           input logic [OUTCOME_W-1:0] outcome);
        t_stim_row row;
        row.item    = mk_item(cmd, x, y, z, status);
        row.typed   = typed;
        row.outcome = outcome;
        directed_rows.push_back(row);
    endtask

    // Leave tvalid high on return so a back-to-back transaction follows cleanly
    task automatic send_item(input t_mag_item it, input bit typed,
                             input logic [OUTCOME_W-1:0] outcome);
        t_field_result want;
        int            gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.status, it.raw};
        s_axis_tuser  <= it.cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        want = predict_fields(it);
        if (typed) begin
            want         = '0;
            want.outcome = outcome;
        end
        expected_fields.push_back(want);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_adjust(input logic [ADJ_W-1:0] ax, ay, az);
        logic [ADJ_W-1:0]       vals    [N_AXES];
        logic [CFG_INDEX_W-1:0] reg_idx [N_AXES];
        int                     a;
        vals[0]    = ax;
        vals[1]    = ay;
        vals[2]    = az;
        reg_idx[0] = REG_ADJUST_X;
        reg_idx[1] = REG_ADJUST_Y;
        reg_idx[2] = REG_ADJUST_Z;
        for (a = 0; a < N_AXES; a++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_idx[a];
            i_cfg_data  <= vals[a];
            do @(posedge i_clk); while (!o_cfg_ready);
            adj_shadow[a] = vals[a];
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : result_sink
        forever begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if (idle_on && $urandom_range(0, 1) == 1) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_field_result want;
        t_field_result got;
        int            a;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.outcome = m_axis_tuser;
            for (a = 0; a < N_AXES; a++) got.fld[a] = m_axis_tdata[a*FIELD_W +: FIELD_W];
            if (expected_fields.size() == 0) begin
                $display("%0t: unexpected transaction, outcome %0d", $time, got.outcome);
                n_errors++;
            end else begin
                want = expected_fields.pop_front();
                if (got.outcome !== want.outcome) begin
                    $display("%0t: outcome expected %0d, got %0d",
                             $time, want.outcome, got.outcome);
                    n_errors++;
                end
                for (a = 0; a < N_AXES; a++) begin
                    if (got.fld[a] !== want.fld[a]) begin
                        $display("%0t: field axis %0d expected %0d, got %0d", $time, a,
                                 $signed(want.fld[a]), $signed(got.fld[a]));
                        n_errors++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        t_mag_item        it;
        logic [RAW_W-1:0] centre [N_AXES];
        int               spread [N_AXES];
        int               p;
        int               a;
        int               k;
        int               r;
        int               n_sent;
        int               n_samples;
        int               n_meas;
        logic [ADJ_W-1:0] set_x;
        logic [ADJ_W-1:0] set_y;
        logic [ADJ_W-1:0] set_z;

        for (a = 0; a < N_AXES; a++) begin
            adj_shadow[a]   = ADJ_RESET;
            bias_shadow[a]  = 0;
            scale_shadow[a] = longint'(SCALE_ONE);
        end
        clear_extremes();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        //      command          x        y        z        status typed outcome
        add_row(CMD_FINISH,      16'h0000, 16'h0000, 16'h0000, 8'h00, 1, OUT_CAL_FAILED);
        add_row(CMD_MEASURE,     16'h0000, 16'h0000, 16'h0000, 8'h00, 1, OUT_MEASURED);
        add_row(CMD_MEASURE,     16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h08, 1, OUT_OVERFLOW);
        add_row(CMD_SAMPLE,      16'h8000, 16'h8000, 16'h8000, 8'hFF, 1, OUT_OVERFLOW);
        add_row(CMD_MEASURE,     16'h7FFF, 16'h7FFF, 16'h7FFF, 8'hF7, 0, OUT_MEASURED);
        add_row(CMD_MEASURE_ALT, 16'h8000, 16'h8000, 16'h8000, 8'h00, 0, OUT_MEASURED);
        add_row(CMD_MEASURE,     16'hFFFF, 16'h0001, 16'h00FF, 8'h00, 0, OUT_MEASURED);
        // a single sample leaves every range empty
        add_row(CMD_SAMPLE,      16'h1234, 16'hABCD, 16'h00FF, 8'h00, 0, OUT_SAMPLED);
        add_row(CMD_FINISH,      16'h0000, 16'h0000, 16'h0000, 8'h00, 1, OUT_CAL_FAILED);
        // full-scale sweep; finish ignores the overflow bit
        add_row(CMD_SAMPLE,      16'h7FFF, 16'h7FFF, 16'h7FFF, 8'hF7, 0, OUT_SAMPLED);
        add_row(CMD_SAMPLE,      16'h8000, 16'h8000, 16'h8000, 8'h00, 0, OUT_SAMPLED);
        add_row(CMD_FINISH,      16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h08, 1, OUT_CALIBRATED);
        add_row(CMD_MEASURE,     16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h00, 0, OUT_MEASURED);
        add_row(CMD_MEASURE,     16'h8000, 16'h8000, 16'h8000, 8'h00, 0, OUT_MEASURED);
        // flat z axis: calibration must stay as it was
        add_row(CMD_SAMPLE,      16'h0064, 16'h0064, 16'h0005, 8'h00, 0, OUT_SAMPLED);
        add_row(CMD_SAMPLE,      16'hFF9C, 16'hFF9C, 16'h0005, 8'h00, 0, OUT_SAMPLED);
        add_row(CMD_FINISH,      16'h0000, 16'h0000, 16'h0000, 8'h00, 1, OUT_CAL_FAILED);
        add_row(CMD_MEASURE,     16'h0064, 16'h0064, 16'h0005, 8'h00, 0, OUT_MEASURED);
        // tiny x range drives the x scale into saturation
        add_row(CMD_SAMPLE,      16'h0000, 16'h7FFF, 16'h7FFF, 8'h00, 0, OUT_SAMPLED);
        add_row(CMD_SAMPLE,      16'h0001, 16'h8000, 16'h8000, 8'h00, 0, OUT_SAMPLED);
        add_row(CMD_FINISH,      16'h0000, 16'h0000, 16'h0000, 8'h00, 1, OUT_CALIBRATED);
        add_row(CMD_MEASURE_ALT, 16'h7FFF, 16'h0000, 16'h8000, 8'h00, 0, OUT_MEASURED);
        add_row(CMD_MEASURE,     16'h8000, 16'h7FFF, 16'h0000, 8'h00, 0, OUT_MEASURED);

        for (r = 0; r < directed_rows.size(); r++)
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].outcome);
        drain_results();

        n_sent = 0;
        for (p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin set_x = 8'd0;   set_y = 8'd0;   set_z = 8'd0;   end
                1: begin set_x = 8'd255; set_y = 8'd255; set_z = 8'd255; end
                2: begin set_x = 8'd128; set_y = 8'd0;   set_z = 8'd255; end
                3: begin set_x = 8'd255; set_y = 8'd128; set_z = 8'd0;   end
                default: begin
                    set_x = ADJ_W'($urandom);
                    set_y = ADJ_W'($urandom);
                    set_z = ADJ_W'($urandom);
                end
            endcase
            write_adjust(set_x, set_y, set_z);
            idle_on = (p != N_PHASES - 1);

            while (n_sent < (p + 1) * N_RANDOM_ITEMS / N_PHASES) begin
                if ($urandom_range(0, 9) < 7) begin
                    // calibration run around an offset centre, then finish and measure
                    for (a = 0; a < N_AXES; a++) begin
                        centre[a] = RAW_W'($urandom_range(0, 16000) - 8000);
                        spread[a] = ($urandom_range(0, 9) == 0) ? 0
                                                                : $urandom_range(20, 20000);
                    end
                    n_samples = $urandom_range(1, 16);
                    for (k = 0; k < n_samples; k++) begin
                        it.cmd = CMD_SAMPLE;
                        for (a = 0; a < N_AXES; a++)
                            it.raw[a] = centre[a]
                                + RAW_W'($urandom_range(0, 2 * spread[a]) - spread[a]);
                        it.status = quiet_status();
                        send_item(it, 1'b0, OUT_MEASURED);
                        n_sent++;
                    end
                    it = mk_item(CMD_FINISH, pick_raw(), pick_raw(), pick_raw(),
                                 STATUS_W'($urandom));
                    send_item(it, 1'b0, OUT_MEASURED);
                    n_sent++;
                    n_meas = $urandom_range(1, 8);
                    for (k = 0; k < n_meas; k++) begin
                        it.cmd = ($urandom_range(0, 3) == 0) ? CMD_MEASURE_ALT : CMD_MEASURE;
                        for (a = 0; a < N_AXES; a++)
                            it.raw[a] = ($urandom_range(0, 3) == 0) ? pick_raw()
                                : centre[a] + RAW_W'($urandom_range(0, 2 * spread[a])
                                                     - spread[a]);
                        it.status = quiet_status();
                        send_item(it, 1'b0, OUT_MEASURED);
                        n_sent++;
                    end
                end else begin
                    it = mk_item(CMD_W'($urandom), pick_raw(), pick_raw(), pick_raw(),
                                 STATUS_W'($urandom));
                    send_item(it, 1'b0, OUT_MEASURED);
                    n_sent++;
                end
            end
            drain_results();
        end

        // hold for longer than the slowest item before judging
        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && expected_fields.size() == 0) begin
            $display("magnetometer_iron_calibration_top verification clean");
        end else begin
            $display("magnetometer_iron_calibration_top verification failed");
        end
        $finish;
    end

endmodule
